FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hal assertion failed");

// Next-cycle implication.
`define HAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hal assertion failed");

`endif

FILE: src/hal_pkg.sv
// ----------------------------------------------------------------------------
// hal_pkg
// Types, codes and defaults for the hotspot alarm lifecycle tracker.
// ----------------------------------------------------------------------------
package hal_pkg;

  localparam int HAL_COUNT_WIDTH = 16;
  localparam int HAL_LEVEL_WIDTH = 16;
  localparam int HAL_CFG_IDX_W   = 8;
  localparam int HAL_CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [HAL_CFG_IDX_W-1:0] REG_CONFIRM_STEPS   = 8'd0;
  localparam logic [HAL_CFG_IDX_W-1:0] REG_SEVERITY        = 8'd1;
  localparam logic [HAL_CFG_IDX_W-1:0] REG_AUTO_DISMISS    = 8'd2;
  localparam logic [HAL_CFG_IDX_W-1:0] REG_RESOLVE_STEPS   = 8'd3;

  localparam logic [7:0]  RST_CONFIRM_STEPS = 8'd3;
  localparam logic [15:0] RST_SEVERITY      = 16'd750;
  localparam logic [15:0] RST_AUTO_DISMISS  = 16'd10;
  localparam logic [7:0]  RST_RESOLVE_STEPS = 8'd3;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_DETECT   = 3'd1,
    KIND_MISS     = 3'd2,
    KIND_CONFIRM  = 3'd3,
    KIND_DISMISS  = 3'd4,
    KIND_MITIGATE = 3'd5
  } kind_t;

  // output encoding of the alarm state
  localparam logic [2:0] CODE_CANDIDATE  = 3'd0;
  localparam logic [2:0] CODE_CONFIRMED  = 3'd1;
  localparam logic [2:0] CODE_ACTIVE     = 3'd2;
  localparam logic [2:0] CODE_MITIGATING = 3'd3;
  localparam logic [2:0] CODE_RESOLVED   = 3'd4;
  localparam logic [2:0] CODE_DISMISSED  = 3'd5;

  typedef enum logic [5:0] {
    ST_CANDIDATE  = 6'b000001,
    ST_CONFIRMED  = 6'b000010,
    ST_ACTIVE     = 6'b000100,
    ST_MITIGATING = 6'b001000,
    ST_RESOLVED   = 6'b010000,
    ST_DISMISSED  = 6'b100000
  } alarm_state_t;

  typedef struct packed {
    logic [7:0]  confirm_steps;
    logic [15:0] severity_threshold;
    logic [15:0] auto_dismiss_steps;
    logic [7:0]  resolve_steps;
  } cfg_t;

  function automatic logic [2:0] state_code(input alarm_state_t st);
    logic [2:0] code;
    case (st)
      ST_CANDIDATE:  code = CODE_CANDIDATE;
      ST_CONFIRMED:  code = CODE_CONFIRMED;
      ST_ACTIVE:     code = CODE_ACTIVE;
      ST_MITIGATING: code = CODE_MITIGATING;
      ST_RESOLVED:   code = CODE_RESOLVED;
      ST_DISMISSED:  code = CODE_DISMISSED;
      default:       code = CODE_CANDIDATE;
    endcase
    return code;
  endfunction

endpackage

FILE: src/hal_if.sv
// ----------------------------------------------------------------------------
// hal_if
// Valid/ready channels: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface hal_in_if #(parameter int LEVEL_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [2:0]             kind;
  logic [LEVEL_WIDTH-1:0] concentration;

  modport source (output valid, kind, concentration, input ready);
  modport sink   (input valid, kind, concentration, output ready);
endinterface

interface hal_out_if #(parameter int COUNT_WIDTH = 16, parameter int LEVEL_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic                   changed;
  logic [2:0]             alarm_state;
  logic                   terminal;
  logic                   live;
  logic [LEVEL_WIDTH-1:0] peak_level;
  logic [LEVEL_WIDTH-1:0] current_level;
  logic [COUNT_WIDTH-1:0] hit_run;
  logic [COUNT_WIDTH-1:0] miss_run;

  modport source (output valid, changed, alarm_state, terminal, live, peak_level,
                  current_level, hit_run, miss_run, input ready);
  modport sink   (input valid, changed, alarm_state, terminal, live, peak_level,
                  current_level, hit_run, miss_run, output ready);
endinterface

interface hal_cfg_if #(parameter int IDX_W = 8, parameter int DATA_W = 16);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/hal_cfg.sv
// ----------------------------------------------------------------------------
// hal_cfg
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module hal_cfg import hal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hal_cfg_if.sink    cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_steps      <= RST_CONFIRM_STEPS;
      cfg_r.severity_threshold <= RST_SEVERITY;
      cfg_r.auto_dismiss_steps <= RST_AUTO_DISMISS;
      cfg_r.resolve_steps      <= RST_RESOLVE_STEPS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CONFIRM_STEPS: cfg_r.confirm_steps      <= cfg_ch.data[7:0];
        REG_SEVERITY:      cfg_r.severity_threshold <= cfg_ch.data[15:0];
        REG_AUTO_DISMISS:  cfg_r.auto_dismiss_steps <= cfg_ch.data[15:0];
        REG_RESOLVE_STEPS: cfg_r.resolve_steps      <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/hal_in_reg.sv
// ----------------------------------------------------------------------------
// hal_in_reg
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module hal_in_reg import hal_pkg::*; #(
  parameter int LEVEL_WIDTH = HAL_LEVEL_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  hal_in_if.sink                 in_ch,
  input  logic                   advance,
  output logic                   item_valid,
  output logic [2:0]             item_kind,
  output logic [LEVEL_WIDTH-1:0] item_level
);

  logic                   valid_r;
  logic [2:0]             kind_r;
  logic [LEVEL_WIDTH-1:0] level_r;
  logic                   take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= in_ch.kind;
      level_r <= in_ch.concentration;
    end
  end

  assign item_valid = valid_r;
  assign item_kind  = kind_r;
  assign item_level = level_r;

endmodule

FILE: src/hal_core.sv
// ----------------------------------------------------------------------------
// hal_core
// Event state and counters; next state for one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module hal_core import hal_pkg::*; #(
  parameter int COUNT_WIDTH = HAL_COUNT_WIDTH,
  parameter int LEVEL_WIDTH = HAL_LEVEL_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   step,
  input  logic [2:0]             kind,
  input  logic [LEVEL_WIDTH-1:0] level,
  output logic                   res_changed,
  output logic [2:0]             res_state,
  output logic                   res_terminal,
  output logic                   res_live,
  output logic [LEVEL_WIDTH-1:0] res_peak,
  output logic [LEVEL_WIDTH-1:0] res_current,
  output logic [COUNT_WIDTH-1:0] res_hit,
  output logic [COUNT_WIDTH-1:0] res_miss
);

  localparam int LVL_CMP_W = (LEVEL_WIDTH > 16) ? LEVEL_WIDTH : 16;
  localparam int AGE_CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic                   live_r,    live_nxt;
  alarm_state_t           state_r,   state_nxt;
  logic [COUNT_WIDTH-1:0] hit_r,     hit_nxt;
  logic [COUNT_WIDTH-1:0] miss_r,    miss_nxt;
  logic [COUNT_WIDTH-1:0] age_r,     age_nxt;
  logic [LEVEL_WIDTH-1:0] peak_r,    peak_nxt;
  logic [LEVEL_WIDTH-1:0] current_r, current_nxt;

  logic [COUNT_WIDTH-1:0] hit_inc, miss_inc, age_inc;
  logic                   severe, confirm_met, resolve_met, age_met;

  assign hit_inc  = (&hit_r)  ? hit_r  : hit_r  + COUNT_WIDTH'(1);
  assign miss_inc = (&miss_r) ? miss_r : miss_r + COUNT_WIDTH'(1);
  assign age_inc  = (&age_r)  ? age_r  : age_r  + COUNT_WIDTH'(1);

  assign severe      = LVL_CMP_W'(level) >= LVL_CMP_W'(cfg.severity_threshold);
  assign confirm_met = hit_inc >= COUNT_WIDTH'(cfg.confirm_steps);
  assign resolve_met = miss_inc >= COUNT_WIDTH'(cfg.resolve_steps);
  assign age_met     = AGE_CMP_W'(age_inc) >= AGE_CMP_W'(cfg.auto_dismiss_steps);

  always_comb begin
    live_nxt    = live_r;
    state_nxt   = state_r;
    hit_nxt     = hit_r;
    miss_nxt    = miss_r;
    age_nxt     = age_r;
    peak_nxt    = peak_r;
    current_nxt = current_r;
    if (step) begin
      if (kind == KIND_START) begin
        live_nxt    = 1'b1;
        state_nxt   = ST_CANDIDATE;
        peak_nxt    = level;
        current_nxt = level;
        hit_nxt     = COUNT_WIDTH'(1);
        miss_nxt    = '0;
        age_nxt     = '0;
      end else if (live_r) begin
        case (kind)
          KIND_DETECT: begin
            age_nxt     = age_inc;
            current_nxt = level;
            if (level > peak_r) peak_nxt = level;
            hit_nxt     = hit_inc;
            miss_nxt    = '0;
            case (state_r)
              ST_CANDIDATE: begin
                if (confirm_met) state_nxt = severe ? ST_ACTIVE : ST_CONFIRMED;
              end
              ST_CONFIRMED, ST_MITIGATING: begin
                if (severe) state_nxt = ST_ACTIVE;
              end
              ST_RESOLVED: begin
                // re-arm
                state_nxt = ST_ACTIVE;
                hit_nxt   = COUNT_WIDTH'(1);
              end
              default: ;
            endcase
          end
          KIND_MISS: begin
            age_nxt  = age_inc;
            hit_nxt  = '0;
            miss_nxt = miss_inc;
            case (state_r)
              ST_CANDIDATE: begin
                if (age_met) state_nxt = ST_DISMISSED;
              end
              ST_CONFIRMED, ST_ACTIVE, ST_MITIGATING: begin
                if (resolve_met) state_nxt = ST_RESOLVED;
              end
              default: ;
            endcase
          end
          KIND_CONFIRM: begin
            if (state_r == ST_CANDIDATE) state_nxt = ST_CONFIRMED;
          end
          KIND_DISMISS: begin
            if (state_r != ST_RESOLVED && state_r != ST_DISMISSED) state_nxt = ST_DISMISSED;
          end
          KIND_MITIGATE: begin
            if (state_r == ST_ACTIVE || state_r == ST_CONFIRMED) state_nxt = ST_MITIGATING;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= 1'b0;
      state_r   <= ST_CANDIDATE;
      hit_r     <= '0;
      miss_r    <= '0;
      age_r     <= '0;
      peak_r    <= '0;
      current_r <= '0;
    end else begin
      live_r    <= live_nxt;
      state_r   <= state_nxt;
      hit_r     <= hit_nxt;
      miss_r    <= miss_nxt;
      age_r     <= age_nxt;
      peak_r    <= peak_nxt;
      current_r <= current_nxt;
    end
  end

  assign res_changed  = step && ((kind == KIND_START) || (state_nxt != state_r));
  assign res_state    = state_code(state_nxt);
  assign res_terminal = (state_nxt == ST_RESOLVED) || (state_nxt == ST_DISMISSED);
  assign res_live     = live_nxt;
  assign res_peak     = peak_nxt;
  assign res_current  = current_nxt;
  assign res_hit      = hit_nxt;
  assign res_miss     = miss_nxt;

`include "assert_macros.svh"

  `HAL_ASSERT_NEXT(a_live_sticky, live_r, live_r)
  `HAL_ASSERT_NOW(a_idle_before_start, !live_r,
                  state_r == ST_CANDIDATE && hit_r == '0 && age_r == '0)
  `HAL_ASSERT_NEXT(a_dismiss_holds,
                   step && state_r == ST_DISMISSED && kind != KIND_START,
                   state_r == ST_DISMISSED)
  `HAL_ASSERT_NOW(a_peak_covers_current, live_r, peak_r >= current_r)

endmodule

FILE: src/hal_out_reg.sv
// ----------------------------------------------------------------------------
// hal_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module hal_out_reg import hal_pkg::*; #(
  parameter int COUNT_WIDTH = HAL_COUNT_WIDTH,
  parameter int LEVEL_WIDTH = HAL_LEVEL_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  output logic                   advance,
  input  logic                   res_changed,
  input  logic [2:0]             res_state,
  input  logic                   res_terminal,
  input  logic                   res_live,
  input  logic [LEVEL_WIDTH-1:0] res_peak,
  input  logic [LEVEL_WIDTH-1:0] res_current,
  input  logic [COUNT_WIDTH-1:0] res_hit,
  input  logic [COUNT_WIDTH-1:0] res_miss,
  hal_out_if.source              out_ch
);

  logic                   valid_r;
  logic                   changed_r;
  logic [2:0]             state_r;
  logic                   terminal_r;
  logic                   live_r;
  logic [LEVEL_WIDTH-1:0] peak_r;
  logic [LEVEL_WIDTH-1:0] current_r;
  logic [COUNT_WIDTH-1:0] hit_r;
  logic [COUNT_WIDTH-1:0] miss_r;

  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      changed_r  <= res_changed;
      state_r    <= res_state;
      terminal_r <= res_terminal;
      live_r     <= res_live;
      peak_r     <= res_peak;
      current_r  <= res_current;
      hit_r      <= res_hit;
      miss_r     <= res_miss;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.changed       = changed_r;
  assign out_ch.alarm_state   = state_r;
  assign out_ch.terminal      = terminal_r;
  assign out_ch.live          = live_r;
  assign out_ch.peak_level    = peak_r;
  assign out_ch.current_level = current_r;
  assign out_ch.hit_run       = hit_r;
  assign out_ch.miss_run      = miss_r;

endmodule

FILE: src/hotspot_alarm_lifecycle.sv
// Item path: an accepted item waits in the input register, the core computes its
// result combinationally and the result register loads it when it can advance.
// Throughput: one item per cycle; the input register and the result register
// stall together only while the result register is full and out_ch.ready is low.
// Reset (rst_n low, synchronous): no event open, state candidate, counters and
// levels zero, thresholds back to 3 / 750 / 10 / 3, both channels empty.
// ----------------------------------------------------------------------------
// hotspot_alarm_lifecycle
// Top level: config registers, input register, lifecycle core, result register.
// ----------------------------------------------------------------------------
module hotspot_alarm_lifecycle import hal_pkg::*; #(
  parameter int COUNT_WIDTH = HAL_COUNT_WIDTH,
  parameter int LEVEL_WIDTH = HAL_LEVEL_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  hal_in_if.sink     in_ch,
  hal_out_if.source  out_ch,
  hal_cfg_if.sink    cfg_ch
);

  cfg_t                   cfg;
  logic                   advance;
  logic                   item_valid;
  logic [2:0]             item_kind;
  logic [LEVEL_WIDTH-1:0] item_level;
  logic                   step;

  logic                   res_changed;
  logic [2:0]             res_state;
  logic                   res_terminal;
  logic                   res_live;
  logic [LEVEL_WIDTH-1:0] res_peak;
  logic [LEVEL_WIDTH-1:0] res_current;
  logic [COUNT_WIDTH-1:0] res_hit;
  logic [COUNT_WIDTH-1:0] res_miss;

  assign step = item_valid && advance;

  hal_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  hal_in_reg #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item_kind  (item_kind),
    .item_level (item_level)
  );

  hal_core #(.COUNT_WIDTH(COUNT_WIDTH), .LEVEL_WIDTH(LEVEL_WIDTH)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (step),
    .kind         (item_kind),
    .level        (item_level),
    .res_changed  (res_changed),
    .res_state    (res_state),
    .res_terminal (res_terminal),
    .res_live     (res_live),
    .res_peak     (res_peak),
    .res_current  (res_current),
    .res_hit      (res_hit),
    .res_miss     (res_miss)
  );

  hal_out_reg #(.COUNT_WIDTH(COUNT_WIDTH), .LEVEL_WIDTH(LEVEL_WIDTH)) u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (item_valid),
    .advance      (advance),
    .res_changed  (res_changed),
    .res_state    (res_state),
    .res_terminal (res_terminal),
    .res_live     (res_live),
    .res_peak     (res_peak),
    .res_current  (res_current),
    .res_hit      (res_hit),
    .res_miss     (res_miss),
    .out_ch       (out_ch)
  );

endmodule

FILE: verif/hotspot_alarm_lifecycle_tb.sv
// ----------------------------------------------------------------------------
// hotspot_alarm_lifecycle_tb
// Self-checking bench for the alarm lifecycle tracker. A directed table runs
// first: items before any start, restarts, the straight-to-active path,
// re-arm, the dismissed state and the unused kinds. Several threshold settings
// follow, each with a run of random event sequences. An in-bench lifecycle
// model predicts each result item, save the table rows that carry their own
// expected result, and results are checked in order.
// ----------------------------------------------------------------------------
module hotspot_alarm_lifecycle_tb import hal_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  typedef struct packed {
    logic        changed;
    logic [2:0]  alarm_state;
    logic        terminal;
    logic        live;
    logic [15:0] peak_level;
    logic [15:0] current_level;
    logic [15:0] hit_run;
    logic [15:0] miss_run;
  } alarm_result_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [15:0]   level;
    logic          typed;
    alarm_result_t want;
  } stim_row_t;

  localparam alarm_result_t NO_EVENT  = '0;
  localparam alarm_result_t OPEN_MAX  = '{changed: 1'b1, alarm_state: CODE_CANDIDATE,
                                          terminal: 1'b0, live: 1'b1,
                                          peak_level: 16'hFFFF, current_level: 16'hFFFF,
                                          hit_run: 16'd1, miss_run: 16'd0};
  localparam alarm_result_t OPEN_ZERO = '{changed: 1'b1, alarm_state: CODE_CANDIDATE,
                                          terminal: 1'b0, live: 1'b1,
                                          peak_level: 16'h0000, current_level: 16'h0000,
                                          hit_run: 16'd1, miss_run: 16'd0};

  // reset thresholds 3 / 750 / 10 / 3 apply to the whole table
  localparam int NUM_ROWS = 27;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{KIND_DETECT,   16'hFFFF, 1'b1, NO_EVENT},
    '{KIND_MISS,     16'h0000, 1'b1, NO_EVENT},
    '{KIND_CONFIRM,  16'h0000, 1'b1, NO_EVENT},
    '{KIND_DISMISS,  16'h0000, 1'b1, NO_EVENT},
    '{KIND_MITIGATE, 16'h0000, 1'b1, NO_EVENT},
    '{KIND_RSVD7,    16'hFFFF, 1'b1, NO_EVENT},
    '{KIND_START,    16'hFFFF, 1'b1, OPEN_MAX},
    '{KIND_START,    16'h0000, 1'b1, OPEN_ZERO},
    '{KIND_DETECT,   16'd100,  1'b0, NO_EVENT},
    '{KIND_DETECT,   16'd800,  1'b0, NO_EVENT},  // confirm and severity together
    '{KIND_MITIGATE, 16'h0000, 1'b0, NO_EVENT},
    '{KIND_DETECT,   16'd750,  1'b0, NO_EVENT},  // exactly at severity
    '{KIND_MISS,     16'h0000, 1'b0, NO_EVENT},
    '{KIND_MISS,     16'h0000, 1'b0, NO_EVENT},
    '{KIND_MISS,     16'h0000, 1'b0, NO_EVENT},
    '{KIND_DETECT,   16'd10,   1'b0, NO_EVENT},  // re-arm from resolved
    '{KIND_RSVD6,    16'h1234, 1'b0, NO_EVENT},
    '{KIND_MITIGATE, 16'h0000, 1'b0, NO_EVENT},
    '{KIND_DISMISS,  16'h0000, 1'b0, NO_EVENT},
    '{KIND_DETECT,   16'hFFFF, 1'b0, NO_EVENT},  // dismissed still tracks levels
    '{KIND_MISS,     16'h0000, 1'b0, NO_EVENT},
    '{KIND_START,    16'h5A5A, 1'b0, NO_EVENT},
    '{KIND_CONFIRM,  16'h0000, 1'b0, NO_EVENT},
    '{KIND_DETECT,   16'd749,  1'b0, NO_EVENT},
    '{KIND_MITIGATE, 16'h0000, 1'b0, NO_EVENT},
    '{KIND_DISMISS,  16'h0000, 1'b0, NO_EVENT},
    '{KIND_DISMISS,  16'h0000, 1'b0, NO_EVENT}
  };

  logic clk;
  logic rst_n;

  hal_in_if  #(.LEVEL_WIDTH(HAL_LEVEL_WIDTH)) in_ch ();
  hal_out_if #(.COUNT_WIDTH(HAL_COUNT_WIDTH), .LEVEL_WIDTH(HAL_LEVEL_WIDTH)) out_ch ();
  hal_cfg_if #(.IDX_W(HAL_CFG_IDX_W), .DATA_W(HAL_CFG_DATA_W)) cfg_ch ();

  hotspot_alarm_lifecycle uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // lifecycle model state
  cfg_t        cfg_q;
  logic        live_q;
  logic [2:0]  code_q;
  logic [15:0] hits_q;
  logic [15:0] misses_q;
  logic [15:0] age_q;
  logic [15:0] peak_q;
  logic [15:0] cur_q;

  alarm_result_t results_due [$];
  int unsigned   errors = 0;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  bit            hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_closed(input logic [2:0] code);
    return (code == CODE_RESOLVED) || (code == CODE_DISMISSED);
  endfunction

  function automatic alarm_result_t advance_alarm(input logic [2:0] k, input logic [15:0] c);
    logic [2:0]    prior;
    alarm_result_t r;
    prior     = code_q;
    r.changed = 1'b0;
    if (k == KIND_START) begin
      live_q    = 1'b1;
      code_q    = CODE_CANDIDATE;
      peak_q    = c;
      cur_q     = c;
      hits_q    = 16'd1;
      misses_q  = 16'd0;
      age_q     = 16'd0;
      r.changed = 1'b1;
    end else if (live_q) begin
      case (k)
        KIND_DETECT: begin
          age_q    = bump(age_q);
          cur_q    = c;
          if (c > peak_q) peak_q = c;
          hits_q   = bump(hits_q);
          misses_q = 16'd0;
          case (code_q)
            CODE_CANDIDATE: begin
              if (hits_q >= cfg_q.confirm_steps)
                code_q = (c >= cfg_q.severity_threshold) ? CODE_ACTIVE : CODE_CONFIRMED;
            end
            CODE_CONFIRMED, CODE_MITIGATING: begin
              if (c >= cfg_q.severity_threshold) code_q = CODE_ACTIVE;
            end
            CODE_RESOLVED: begin
              code_q = CODE_ACTIVE;
              hits_q = 16'd1;
            end
            default: ;
          endcase
        end
        KIND_MISS: begin
          age_q    = bump(age_q);
          hits_q   = 16'd0;
          misses_q = bump(misses_q);
          case (code_q)
            CODE_CANDIDATE: begin
              if (age_q >= cfg_q.auto_dismiss_steps) code_q = CODE_DISMISSED;
            end
            CODE_CONFIRMED, CODE_ACTIVE, CODE_MITIGATING: begin
              if (misses_q >= cfg_q.resolve_steps) code_q = CODE_RESOLVED;
            end
            default: ;
          endcase
        end
        KIND_CONFIRM: begin
          if (code_q == CODE_CANDIDATE) code_q = CODE_CONFIRMED;
        end
        KIND_DISMISS: begin
          if (!is_closed(code_q)) code_q = CODE_DISMISSED;
        end
        KIND_MITIGATE: begin
          if (code_q == CODE_ACTIVE || code_q == CODE_CONFIRMED) code_q = CODE_MITIGATING;
        end
        default: ;
      endcase
      r.changed = (code_q != prior);
    end
    r.alarm_state   = code_q;
    r.terminal      = is_closed(code_q);
    r.live          = live_q;
    r.peak_level    = peak_q;
    r.current_level = cur_q;
    r.hit_run       = hits_q;
    r.miss_run      = misses_q;
    return r;
  endfunction

  function automatic string show_result(input alarm_result_t r);
    return $sformatf("chg=%0d st=%0d term=%0d live=%0d peak=%0h cur=%0h hit=%0h miss=%0h",
                     r.changed, r.alarm_state, r.terminal, r.live, r.peak_level,
                     r.current_level, r.hit_run, r.miss_run);
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  // values near the severity threshold, values up to 1000, extremes and noise
  function automatic logic [15:0] pick_level();
    int unsigned near;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        near = cfg_q.severity_threshold + $urandom_range(0, 4);
        if (near < 2) return 16'h0000;
        if (near - 2 > 65535) return 16'hFFFF;
        return 16'(near - 2);
      end
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic offer_item(input logic [2:0] k, input logic [15:0] c,
                            input logic typed = 1'b0, input alarm_result_t want = '0);
    alarm_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.concentration <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_alarm(k, c);
    results_due.insert(results_due.size(), typed ? want : predicted);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] cs, input logic [15:0] sev,
                              input logic [15:0] ad, input logic [7:0] rs);
    logic [HAL_CFG_IDX_W-1:0] regs [4];
    logic [15:0]              vals [4];
    int                       i;
    regs = '{REG_CONFIRM_STEPS, REG_SEVERITY, REG_AUTO_DISMISS, REG_RESOLVE_STEPS};
    vals = '{{8'd0, cs}, sev, ad, {8'd0, rs}};
    wait_drain();
    for (i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (regs[i])
        REG_CONFIRM_STEPS: cfg_q.confirm_steps      = vals[i][7:0];
        REG_SEVERITY:      cfg_q.severity_threshold = vals[i];
        REG_AUTO_DISMISS:  cfg_q.auto_dismiss_steps = vals[i];
        REG_RESOLVE_STEPS: cfg_q.resolve_steps      = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // event sequences: a start, then runs of detections and misses mixed
  // with manual actions, restarts and unused kinds
  task automatic run_events(input int n);
    int         count;
    int         len;
    int         pick;
    logic [2:0] k;
    count = 1;
    offer_item(KIND_START, pick_level());
    while (count < n) begin
      pick = $urandom_range(0, 99);
      len  = 1;
      if (pick < 40) begin
        k   = KIND_DETECT;
        len = $urandom_range(1, 8);
      end else if (pick < 65) begin
        k   = KIND_MISS;
        len = $urandom_range(1, 10);
      end else if (pick < 73) begin
        k = KIND_CONFIRM;
      end else if (pick < 81) begin
        k = KIND_MITIGATE;
      end else if (pick < 86) begin
        k = KIND_DISMISS;
      end else if (pick < 92) begin
        k = KIND_START;
      end else begin
        k = $urandom_range(0, 1) ? KIND_RSVD6 : KIND_RSVD7;
      end
      while (len > 0 && count < n) begin
        offer_item(k, (k == KIND_DETECT || k == KIND_START) ? pick_level() : 16'($urandom));
        count++;
        len--;
      end
    end
  endtask

  // receiver: random stalls, or one long counted hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    alarm_result_t got;
    alarm_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.changed, out_ch.alarm_state, out_ch.terminal, out_ch.live,
             out_ch.peak_level, out_ch.current_level, out_ch.hit_run, out_ch.miss_run};
      if (results_due.size() == 0) begin
        flag_error({"unexpected result: ", show_result(got)});
      end else begin
        want = results_due.pop_front();
        if (got !== want)
          flag_error({"mismatch: expected ", show_result(want), " actual ", show_result(got)});
      end
    end
  end

  initial begin : stimulus
    int r;
    int seg;
    int n;
    hold_req            = 1'b0;
    tx_idle_pct         = 8;
    rx_idle_pct         = 79;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_START;
    in_ch.concentration = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_CONFIRM_STEPS;
    cfg_ch.data         = '0;
    cfg_q    = '{confirm_steps: RST_CONFIRM_STEPS, severity_threshold: RST_SEVERITY,
                 auto_dismiss_steps: RST_AUTO_DISMISS, resolve_steps: RST_RESOLVE_STEPS};
    live_q   = 1'b0;
    code_q   = CODE_CANDIDATE;
    hits_q   = '0;
    misses_q = '0;
    age_q    = '0;
    peak_q   = '0;
    cur_q    = '0;
    rst_n    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++)
      offer_item(DIRECTED[r].kind, DIRECTED[r].level, DIRECTED[r].typed, DIRECTED[r].want);

    for (seg = 0; seg < 9; seg++) begin
      case (seg / 3)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 79;
        end
        1: begin
          tx_idle_pct = 79;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg)
        0: apply_config(8'd1, 16'd0, 16'd1, 8'd1);
        1: apply_config(8'd255, 16'hFFFF, 16'hFFFF, 8'd255);
        2: apply_config(8'd2, 16'd750, 16'd12, 8'd2);
        3: apply_config(8'd3, 16'd40000, 16'd6, 8'd4);
        4: apply_config(8'd1, 16'hFFFF, 16'd3, 8'd1);
        default: apply_config(8'($urandom_range(1, 6)), 16'($urandom),
                              16'($urandom_range(1, 20)), 8'($urandom_range(1, 6)));
      endcase
      n = 50;
      if (seg == 4) begin
        // receiver holds off while the sender keeps pushing items
        tx_idle_pct = 0;
        hold_req    = 1'b1;
        run_events(24);
        tx_idle_pct = 79;
        n = 26;
      end
      run_events(n);
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
